// ----- rtl/event_latency_log2_histogram_core_defines.svh -----
// Assertion macros shared by the latency histogram RTL.
`ifndef EVENT_LATENCY_LOG2_HISTOGRAM_CORE_DEFINES_SVH
`define EVENT_LATENCY_LOG2_HISTOGRAM_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ELH_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ELH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/elh_pkg.sv -----
// Shared constants, command and status types and helpers for the latency histogram.
package elh_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int MAX_BUCKET_DEF  = 26;

   localparam int TIME_W    = 64;
   localparam int LAT_W     = 55;
   localparam int ACTION_W  = 2;
   localparam int NS_PER_US = 1000;

   // Radix-16 long division by NS_PER_US, one quotient digit per step.
   localparam int DIGIT_W   = 4;
   localparam int DLOG_W    = $clog2(DIGIT_W);
   localparam int DIV_STEPS = TIME_W / DIGIT_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);
   localparam int REM_W     = $clog2(NS_PER_US);
   localparam int PART_W    = REM_W + DIGIT_W;
   localparam int LOG_W     = $clog2(TIME_W);

   localparam logic [ACTION_W-1:0] ACT_START = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_END   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

   typedef struct packed {
      logic accept;
      logic clr_step;
      logic tbl_rd;
      logic tbl_wr_start;
      logic div_start;
      logic hist_rd_bkt;
      logic hist_rd_idx;
      logic end_commit;
      logic res_clear;
      logic res_read;
      logic rsp_load;
   } elh_cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                slot_ok;
      logic                tbl_valid;
      logic                div_busy;
      logic                clr_last;
      logic                rsp_free;
   } elh_sts_type;

   function automatic logic [DLOG_W-1:0] digit_log2(input logic [DIGIT_W-1:0] d);
      logic [DLOG_W-1:0] r;
      if (d[3]) begin
         r = 2'd3;
      end else if (d[2]) begin
         r = 2'd2;
      end else if (d[1]) begin
         r = 2'd1;
      end else begin
         r = 2'd0;
      end
      return r;
   endfunction

endpackage

// ----- rtl/event_latency_log2_histogram_core.sv -----
// Top level of the log2 latency histogram: controller and datapath joined by command/status.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  action, thread_slot, now_ns, read_index
//   rsp_      out        rsp_valid / rsp_stall  matched, elapsed_us, bucket, read_value
//
// A start or an unused action goes from dispatch to done; a read adds a histogram read; an
// end looks up the start table, and a matched end then runs the 16-step radix-16 divider
// and updates the histogram. After reset a clearing pass empties the start table valid
// bits and the histogram; req_stall stays high meanwhile. A finished result waits in the
// output register while the next request is accepted, and only the hand-off of the
// following result waits on rsp_stall.
module event_latency_log2_histogram_core import elh_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int MAX_BUCKET  = MAX_BUCKET_DEF,
   localparam int SLOT_W     = $clog2(TABLE_DEPTH),
   localparam int BUCKET_W   = $clog2(MAX_BUCKET + 1),
   localparam int RIDX_W     = $clog2(MAX_BUCKET + 2)
) (
   input  logic                clock,
   input  logic                reset,

   // Request channel.
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [SLOT_W-1:0]   req_thread_slot,
   input  logic [TIME_W-1:0]   req_now_ns,
   input  logic [RIDX_W-1:0]   req_read_index,

   // Response channel.
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_matched,
   output logic [LAT_W-1:0]    rsp_elapsed_us,
   output logic [BUCKET_W-1:0] rsp_bucket,
   output logic [TIME_W-1:0]   rsp_read_value
);

   // The controller decides what happens in each cycle; the datapath carries the
   // transaction fields, both memories, the running sum and the output register, and
   // reports back only what the controller needs to branch on.
   elh_cmd_type cmd;
   elh_sts_type sts;

   elh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the start timestamps with their valid flags in one memory,
   // the bucket counts in a second memory and the latency sum in its own register.
   elh_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_BUCKET  (MAX_BUCKET)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_action      (req_action),
      .req_thread_slot (req_thread_slot),
      .req_now_ns      (req_now_ns),
      .req_read_index  (req_read_index),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_matched     (rsp_matched),
      .rsp_elapsed_us  (rsp_elapsed_us),
      .rsp_bucket      (rsp_bucket),
      .rsp_read_value  (rsp_read_value)
   );

endmodule

// ----- rtl/elh_div.sv -----
// Iterative radix-16 divider by one thousand that also finds floor log2 of the quotient.
module elh_div import elh_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TIME_W-1:0] dividend,
   output logic              busy,
   output logic [TIME_W-1:0] quotient,
   output logic [LOG_W-1:0]  log2_val
);

   logic [TIME_W-1:0] shift_ff, shift_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              found_ff, found_in;
   logic [LOG_W-1:0]  log_ff, log_in;
   logic [PART_W-1:0] part;
   logic [PART_W-1:0] part_rem;
   logic [DIGIT_W-1:0] digit;
   logic [STEP_W-1:0] pos;

   always_comb begin
      part  = {rem_ff, shift_ff[TIME_W-1 -: DIGIT_W]};
      digit = '0;
      for (int k = 1; k < (1 << DIGIT_W); k++) begin
         if (part >= PART_W'(k * NS_PER_US)) begin
            digit = DIGIT_W'(k);
         end
      end
      part_rem = part - PART_W'(digit * NS_PER_US);
      pos      = STEP_W'(DIV_STEPS - 1) - step_ff;

      shift_in = shift_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      found_in = found_ff;
      log_in   = log_ff;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         step_in  = '0;
         busy_in  = 1'b1;
         found_in = 1'b0;
         log_in   = '0;
      end else if (busy_ff) begin
         shift_in = {shift_ff[TIME_W-DIGIT_W-1:0], digit};
         rem_in   = part_rem[REM_W-1:0];
         step_in  = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
         // The first non-zero digit fixes the position of the leading one.
         if (!found_ff && (digit != '0)) begin
            found_in = 1'b1;
            log_in   = LOG_W'({pos, digit_log2(digit)});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      found_ff <= found_in;
      log_ff   <= log_in;
   end

   assign busy     = busy_ff;
   assign quotient = shift_ff;
   assign log2_val = log_ff;

endmodule

// ----- rtl/elh_ctrl.sv -----
// Controller state machine that sequences clearing, events, reads and result hand-off.
`include "event_latency_log2_histogram_core_defines.svh"
module elh_ctrl import elh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  elh_sts_type sts,
   output elh_cmd_type cmd
);

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_CLEAR  = 3'd0;
   localparam logic [ST_W-1:0] ST_IDLE   = 3'd1;
   localparam logic [ST_W-1:0] ST_DISP   = 3'd2;
   localparam logic [ST_W-1:0] ST_LOOKUP = 3'd3;
   localparam logic [ST_W-1:0] ST_DIV    = 3'd4;
   localparam logic [ST_W-1:0] ST_HUPD   = 3'd5;
   localparam logic [ST_W-1:0] ST_RREAD  = 3'd6;
   localparam logic [ST_W-1:0] ST_DONE   = 3'd7;

   logic [ST_W-1:0] state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DISP;
            end
         end
         ST_DISP: begin
            case (sts.action)
               ACT_START: begin
                  cmd.tbl_wr_start = sts.slot_ok;
                  cmd.res_clear    = 1'b1;
                  state_in         = ST_DONE;
               end
               ACT_END: begin
                  if (sts.slot_ok) begin
                     cmd.tbl_rd = 1'b1;
                     state_in   = ST_LOOKUP;
                  end else begin
                     cmd.res_clear = 1'b1;
                     state_in      = ST_DONE;
                  end
               end
               ACT_READ: begin
                  cmd.hist_rd_idx = 1'b1;
                  state_in        = ST_RREAD;
               end
               default: begin
                  cmd.res_clear = 1'b1;
                  state_in      = ST_DONE;
               end
            endcase
         end
         ST_LOOKUP: begin
            if (sts.tbl_valid) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.res_clear = 1'b1;
               state_in      = ST_DONE;
            end
         end
         ST_DIV: begin
            if (!sts.div_busy) begin
               cmd.hist_rd_bkt = 1'b1;
               state_in        = ST_HUPD;
            end
         end
         ST_HUPD: begin
            cmd.end_commit = 1'b1;
            state_in       = ST_DONE;
         end
         ST_RREAD: begin
            cmd.res_read = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   `ELH_ASSERT_IMP(a_rsp_room, cmd.rsp_load, sts.rsp_free, "result loaded over an untaken one")
   `ELH_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({cmd.accept, cmd.div_start, cmd.end_commit, cmd.rsp_load}), "conflicting commands")
   `ELH_ASSERT_IMP(a_div_match, cmd.div_start, sts.slot_ok && sts.tbl_valid, "division without a matched start")
   `ELH_ASSERT_NEXT(a_div_exit, (state_ff == ST_DIV) && !sts.div_busy, state_ff == ST_HUPD, "division exit missed")
   `ELH_ASSERT_NEXT(a_clr_exit, (state_ff == ST_CLEAR) && sts.clr_last, state_ff == ST_IDLE, "clearing pass overran")

endmodule

// ----- rtl/elh_dpath.sv -----
// Datapath: item registers, start table, histogram memory, sum, divider and result registers.
module elh_dpath import elh_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int MAX_BUCKET  = MAX_BUCKET_DEF,
   localparam int SLOT_W  = $clog2(TABLE_DEPTH),
   localparam int HIST_N  = MAX_BUCKET + 1,
   localparam int HADDR_W = $clog2(HIST_N),
   localparam int RIDX_W  = $clog2(MAX_BUCKET + 2)
) (
   input  logic                clock,
   input  logic                reset,
   input  elh_cmd_type         cmd,
   output elh_sts_type         sts,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [SLOT_W-1:0]   req_thread_slot,
   input  logic [TIME_W-1:0]   req_now_ns,
   input  logic [RIDX_W-1:0]   req_read_index,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic                rsp_matched,
   output logic [LAT_W-1:0]    rsp_elapsed_us,
   output logic [HADDR_W-1:0]  rsp_bucket,
   output logic [TIME_W-1:0]   rsp_read_value
);

   localparam int CLR_N = (TABLE_DEPTH > HIST_N) ? TABLE_DEPTH : HIST_N;
   localparam int CLR_W = $clog2(CLR_N);

   logic [ACTION_W-1:0] itm_action_ff, itm_action_in;
   logic [SLOT_W-1:0]   itm_slot_ff, itm_slot_in;
   logic [TIME_W-1:0]   itm_now_ff, itm_now_in;
   logic [RIDX_W-1:0]   itm_ridx_ff, itm_ridx_in;
   logic [CLR_W-1:0]    clr_ff, clr_in;
   logic [HADDR_W-1:0]  bkt_ff, bkt_in;
   logic [TIME_W-1:0]   sum_ff, sum_in;
   logic                res_matched_ff, res_matched_in;
   logic [LAT_W-1:0]    res_lat_ff, res_lat_in;
   logic [HADDR_W-1:0]  res_bucket_ff, res_bucket_in;
   logic [TIME_W-1:0]   res_read_ff, res_read_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_matched_ff, rsp_matched_in;
   logic [LAT_W-1:0]    rsp_lat_ff, rsp_lat_in;
   logic [HADDR_W-1:0]  rsp_bucket_ff, rsp_bucket_in;
   logic [TIME_W-1:0]   rsp_read_ff, rsp_read_in;

   logic [TIME_W:0]     tbl_mem [TABLE_DEPTH];
   logic [TIME_W:0]     tbl_rd_ff;
   logic                tbl_we;
   logic [SLOT_W-1:0]   tbl_wa;
   logic [TIME_W:0]     tbl_wd;

   logic [TIME_W-1:0]   hist_mem [HIST_N];
   logic [TIME_W-1:0]   hist_rd_ff;
   logic                hist_we;
   logic                hist_re;
   logic [HADDR_W-1:0]  hist_wa;
   logic [HADDR_W-1:0]  hist_ra;
   logic [TIME_W-1:0]   hist_wd;

   logic                slot_ok;
   logic                clr_in_tbl;
   logic                clr_in_hist;
   logic                ridx_in_hist;
   logic                ridx_is_sum;
   logic [HADDR_W-1:0]  bkt_cap;
   logic [TIME_W-1:0]   diff;
   logic                div_busy;
   logic [TIME_W-1:0]   div_quo;
   logic [LOG_W-1:0]    div_log;

   elh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (diff),
      .busy     (div_busy),
      .quotient (div_quo),
      .log2_val (div_log)
   );

   always_comb begin
      slot_ok      = {1'b0, itm_slot_ff} < (SLOT_W + 1)'(TABLE_DEPTH);
      clr_in_tbl   = {1'b0, clr_ff} < (CLR_W + 1)'(TABLE_DEPTH);
      clr_in_hist  = {1'b0, clr_ff} < (CLR_W + 1)'(HIST_N);
      ridx_in_hist = itm_ridx_ff <= RIDX_W'(MAX_BUCKET);
      ridx_is_sum  = itm_ridx_ff == RIDX_W'(MAX_BUCKET + 1);
      bkt_cap      = (div_log > LOG_W'(MAX_BUCKET)) ? HADDR_W'(MAX_BUCKET)
                                                    : div_log[HADDR_W-1:0];
      diff         = itm_now_ff - tbl_rd_ff[TIME_W-1:0];

      tbl_we = (cmd.clr_step && clr_in_tbl) || cmd.tbl_wr_start || cmd.end_commit;
      tbl_wa = cmd.clr_step ? clr_ff[SLOT_W-1:0] : itm_slot_ff;
      tbl_wd = cmd.tbl_wr_start ? {1'b1, itm_now_ff} : '0;

      hist_we = (cmd.clr_step && clr_in_hist) || cmd.end_commit;
      hist_wa = cmd.clr_step ? clr_ff[HADDR_W-1:0] : bkt_ff;
      hist_wd = cmd.clr_step ? '0 : hist_rd_ff + TIME_W'(1);
      hist_re = cmd.hist_rd_bkt || cmd.hist_rd_idx;
      if (cmd.hist_rd_bkt) begin
         hist_ra = bkt_cap;
      end else if (ridx_in_hist) begin
         hist_ra = itm_ridx_ff[HADDR_W-1:0];
      end else begin
         hist_ra = '0;
      end
   end

   always_comb begin
      itm_action_in = itm_action_ff;
      itm_slot_in   = itm_slot_ff;
      itm_now_in    = itm_now_ff;
      itm_ridx_in   = itm_ridx_ff;
      if (cmd.accept) begin
         itm_action_in = req_action;
         itm_slot_in   = req_thread_slot;
         itm_now_in    = req_now_ns;
         itm_ridx_in   = req_read_index;
      end

      clr_in = cmd.clr_step ? clr_ff + 1'b1 : clr_ff;
      bkt_in = cmd.hist_rd_bkt ? bkt_cap : bkt_ff;
      sum_in = cmd.end_commit ? sum_ff + div_quo : sum_ff;

      res_matched_in = res_matched_ff;
      res_lat_in     = res_lat_ff;
      res_bucket_in  = res_bucket_ff;
      res_read_in    = res_read_ff;
      if (cmd.res_clear) begin
         res_matched_in = 1'b0;
         res_lat_in     = '0;
         res_bucket_in  = '0;
         res_read_in    = '0;
      end else if (cmd.end_commit) begin
         res_matched_in = 1'b1;
         res_lat_in     = div_quo[LAT_W-1:0];
         res_bucket_in  = bkt_ff;
         res_read_in    = '0;
      end else if (cmd.res_read) begin
         res_matched_in = 1'b0;
         res_lat_in     = '0;
         res_bucket_in  = '0;
         if (ridx_in_hist) begin
            res_read_in = hist_rd_ff;
         end else if (ridx_is_sum) begin
            res_read_in = sum_ff;
         end else begin
            res_read_in = '0;
         end
      end

      rsp_valid_in   = rsp_valid_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_lat_in     = rsp_lat_ff;
      rsp_bucket_in  = rsp_bucket_ff;
      rsp_read_in    = rsp_read_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_matched_in = res_matched_ff;
         rsp_lat_in     = res_lat_ff;
         rsp_bucket_in  = res_bucket_ff;
         rsp_read_in    = res_read_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      itm_action_ff  <= itm_action_in;
      itm_slot_ff    <= itm_slot_in;
      itm_now_ff     <= itm_now_in;
      itm_ridx_ff    <= itm_ridx_in;
      bkt_ff         <= bkt_in;
      res_matched_ff <= res_matched_in;
      res_lat_ff     <= res_lat_in;
      res_bucket_ff  <= res_bucket_in;
      res_read_ff    <= res_read_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_lat_ff     <= rsp_lat_in;
      rsp_bucket_ff  <= rsp_bucket_in;
      rsp_read_ff    <= rsp_read_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_wa] <= tbl_wd;
      end
      if (cmd.tbl_rd) begin
         tbl_rd_ff <= tbl_mem[itm_slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_wa] <= hist_wd;
      end
      if (hist_re) begin
         hist_rd_ff <= hist_mem[hist_ra];
      end
   end

   always_comb begin
      sts.action    = itm_action_ff;
      sts.slot_ok   = slot_ok;
      sts.tbl_valid = tbl_rd_ff[TIME_W];
      sts.div_busy  = div_busy;
      sts.clr_last  = clr_ff == CLR_W'(CLR_N - 1);
      sts.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_matched    = rsp_matched_ff;
   assign rsp_elapsed_us = rsp_lat_ff;
   assign rsp_bucket     = rsp_bucket_ff;
   assign rsp_read_value = rsp_read_ff;

endmodule

// ----- sim/event_latency_log2_histogram_core_test.sv -----
// Self-checking testbench for the log2 latency histogram core: directed and random traffic.
module event_latency_log2_histogram_core_test import elh_pkg::*;;

   // The block is built with its default sizes, so the widths below follow those.
   localparam int TABLE_SLOTS    = TABLE_DEPTH_DEF;
   localparam int TOP_BUCKET     = MAX_BUCKET_DEF;
   localparam int SUM_INDEX      = TOP_BUCKET + 1;
   localparam int SLOT_W         = $clog2(TABLE_SLOTS);
   localparam int BUCKET_W       = $clog2(TOP_BUCKET + 1);
   localparam int RIDX_W         = $clog2(TOP_BUCKET + 2);
   localparam int RANDOM_ITEMS   = 750;
   localparam int IDLE_PERCENT   = 23;
   localparam int HOLD_OFF_LEN   = 300;
   // The settle pauses allow comfortably for the longest end transaction.
   localparam int SETTLE_CYCLES  = 40;
   // The clearing pass after reset and the long receiver hold-off are the longest stretches
   // without any handshake, so the limit sits well above both.
   localparam int WATCHDOG_LIMIT = 4000;

   // The package names no code for the fourth action value, which the block must ignore.
   localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

   typedef struct packed {
      logic                matched;
      logic [LAT_W-1:0]    elapsed_us;
      logic [BUCKET_W-1:0] bucket;
      logic [TIME_W-1:0]   read_value;
   } hist_reply_type;

   // Shadow copy of the histogram state. Every accepted request transaction updates it and
   // queues the reply that the block ought to send; every accepted reply is checked against
   // the oldest one waiting.
   class histogram_scoreboard_type;
      logic [TIME_W-1:0] stamp_ns [TABLE_SLOTS];
      bit                stamp_live [TABLE_SLOTS];
      logic [TIME_W-1:0] bucket_tally [TOP_BUCKET + 1];
      logic [TIME_W-1:0] latency_sum;
      hist_reply_type    awaited_replies [$];
      int unsigned       fault_count;

      function new();
         foreach (stamp_ns[i]) begin
            stamp_ns[i] = '0;
            stamp_live[i] = 1'b0;
         end
         foreach (bucket_tally[i]) begin
            bucket_tally[i] = '0;
         end
         latency_sum = '0;
         fault_count = 0;
      endfunction

      function int pending();
         return awaited_replies.size();
      endfunction

      function void note_request(input logic [ACTION_W-1:0] action,
                                 input logic [SLOT_W-1:0] slot,
                                 input logic [TIME_W-1:0] now,
                                 input logic [RIDX_W-1:0] ridx);
         hist_reply_type    reply;
         logic [TIME_W-1:0] lat;
         logic [TIME_W-1:0] shifted;
         int unsigned       octave;
         reply = '0;
         case (action)
            ACT_START: begin
               stamp_ns[slot] = now;
               stamp_live[slot] = 1'b1;
            end
            ACT_END: begin
               if (stamp_live[slot]) begin
                  // Elapsed time wraps modulo 2^64 before it is scaled to microseconds.
                  lat = (now - stamp_ns[slot]) / TIME_W'(NS_PER_US);
                  octave = 0;
                  shifted = lat;
                  while (shifted > 1) begin
                     shifted = shifted >> 1;
                     octave++;
                  end
                  if (octave > TOP_BUCKET) begin
                     octave = TOP_BUCKET;
                  end
                  bucket_tally[octave] = bucket_tally[octave] + 1;
                  latency_sum = latency_sum + lat;
                  stamp_live[slot] = 1'b0;
                  reply.matched = 1'b1;
                  reply.elapsed_us = lat[LAT_W-1:0];
                  reply.bucket = BUCKET_W'(octave);
               end
            end
            ACT_READ: begin
               if (ridx <= TOP_BUCKET) begin
                  reply.read_value = bucket_tally[ridx];
               end else if (ridx == SUM_INDEX) begin
                  reply.read_value = latency_sum;
               end
            end
            default: begin
            end
         endcase
         awaited_replies.push_back(reply);
      endfunction

      function void check_reply(input logic                matched,
                                input logic [LAT_W-1:0]    elapsed_us,
                                input logic [BUCKET_W-1:0] bucket,
                                input logic [TIME_W-1:0]   read_value);
         hist_reply_type want;
         if (awaited_replies.size() == 0) begin
            $display("%0t: reply with none outstanding: matched %0d elapsed_us %0d bucket %0d",
                     $time, matched, elapsed_us, bucket);
            fault_count++;
         end else begin
            want = awaited_replies.pop_front();
            if (matched !== want.matched) begin
               $display("%0t: matched expected %0d, got %0d", $time, want.matched, matched);
               fault_count++;
            end
            if (elapsed_us !== want.elapsed_us) begin
               $display("%0t: elapsed_us expected %0d, got %0d",
                        $time, want.elapsed_us, elapsed_us);
               fault_count++;
            end
            if (bucket !== want.bucket) begin
               $display("%0t: bucket expected %0d, got %0d", $time, want.bucket, bucket);
               fault_count++;
            end
            if (read_value !== want.read_value) begin
               $display("%0t: read_value expected %0d, got %0d",
                        $time, want.read_value, read_value);
               fault_count++;
            end
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [ACTION_W-1:0] req_action;
   logic [SLOT_W-1:0]   req_thread_slot;
   logic [TIME_W-1:0]   req_now_ns;
   logic [RIDX_W-1:0]   req_read_index;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_matched;
   logic [LAT_W-1:0]    rsp_elapsed_us;
   logic [BUCKET_W-1:0] rsp_bucket;
   logic [TIME_W-1:0]   rsp_read_value;

   histogram_scoreboard_type board;

   // Shared between the stimulus and the receiver: a stretch in which neither side idles,
   // and a request for the receiver to hold off for a long while.
   bit steady;
   bit hold_off_request;
   int quiet_cycles;

   // What the stimulus has issued, so that end transactions can be aimed at open slots with
   // a chosen elapsed time. Stale entries in the list of open slots are harmless.
   logic [TIME_W-1:0] issued_at [TABLE_SLOTS];
   bit                issued_open [TABLE_SLOTS];
   int                open_slots [$];

   event_latency_log2_histogram_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_thread_slot (req_thread_slot),
      .req_now_ns      (req_now_ns),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_matched     (rsp_matched),
      .rsp_elapsed_us  (rsp_elapsed_us),
      .rsp_bucket      (rsp_bucket),
      .rsp_read_value  (rsp_read_value)
   );

   initial begin
      clock = 1'b0;
   end

   always #1 clock = ~clock;

   // Replies are sampled at the rising edge at which the handshake completes.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_reply(rsp_matched, rsp_elapsed_us, rsp_bucket, rsp_read_value);
      end
   end

   // The watchdog counts cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("event_latency_log2_histogram_core_test: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // The receiver changes its stall at the falling edge. It idles at random, keeps still
   // during the steady stretch, and on request holds off for a long run of cycles so that
   // the block backs up and stalls its request channel.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall = 1'b1;
            repeat (HOLD_OFF_LEN) @(negedge clock);
         end else if (steady) begin
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = ($urandom_range(0, 99) < IDLE_PERCENT);
         end
      end
   end

   // Offers one request transaction and returns at the rising edge that accepts it. Idle
   // cycles fall only before the offer, so valid and payload stay put while stalled.
   task automatic offer(input logic [ACTION_W-1:0] action,
                        input logic [SLOT_W-1:0]   slot,
                        input logic [TIME_W-1:0]   now,
                        input logic [RIDX_W-1:0]   ridx);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_action = action;
      req_thread_slot = slot;
      req_now_ns = now;
      req_read_index = ridx;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      board.note_request(action, slot, now, ridx);
   endtask

   // Valid drops first, so that the transaction just accepted is not offered a second time
   // while the sender waits.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (board.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One random transaction. Most are start/end pairs on open slots, whose elapsed time is
   // a random 64-bit value shifted down by a random amount so that every bucket is reached.
   // The rest are ends on arbitrary slots, reads of any index and the unused action.
   task automatic random_item();
      int                roll;
      int                pick;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] span;
      roll = $urandom_range(0, 99);
      now = {$urandom, $urandom};
      if (roll < 38) begin
         // Starts mostly land in a small window, so overwrites of open slots are common.
         if ($urandom_range(0, 3) == 0) begin
            slot = SLOT_W'($urandom);
         end else begin
            slot = SLOT_W'($urandom_range(0, 31));
         end
         issued_at[slot] = now;
         if (!issued_open[slot]) begin
            open_slots.push_back(slot);
         end
         issued_open[slot] = 1'b1;
         offer(ACT_START, slot, now, RIDX_W'($urandom));
      end else if (roll < 78 && open_slots.size() != 0) begin
         pick = $urandom_range(0, open_slots.size() - 1);
         slot = SLOT_W'(open_slots[pick]);
         open_slots.delete(pick);
         issued_open[slot] = 1'b0;
         span = {$urandom, $urandom} >> $urandom_range(0, 63);
         offer(ACT_END, slot, issued_at[slot] + span, RIDX_W'($urandom));
      end else if (roll < 85) begin
         slot = SLOT_W'($urandom);
         issued_open[slot] = 1'b0;
         offer(ACT_END, slot, now, RIDX_W'($urandom));
      end else if (roll < 96) begin
         offer(ACT_READ, SLOT_W'($urandom), now, RIDX_W'($urandom_range(0, 31)));
      end else begin
         offer(ACT_SPARE, SLOT_W'($urandom), now, RIDX_W'($urandom));
      end
   endtask

   initial begin
      board = new();
      steady = 1'b0;
      hold_off_request = 1'b0;
      quiet_cycles = 0;
      foreach (issued_open[i]) begin
         issued_open[i] = 1'b0;
         issued_at[i] = '0;
      end
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_START;
      req_thread_slot = '0;
      req_now_ns = '0;
      req_read_index = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. The block holds off requests during its clearing pass; the offers
      // simply wait for it. Reads of an empty histogram, of the sum, and past the sum.
      offer(ACT_READ, '0, '0, '0);
      offer(ACT_READ, '0, '0, RIDX_W'(SUM_INDEX));
      offer(ACT_READ, '0, '0, '1);
      offer(ACT_SPARE, '1, '1, '1);
      // An end on a slot that was never started must not match.
      offer(ACT_END, SLOT_W'(5), 64'd12345, '0);
      // Less than a microsecond elapsed lands in bucket zero.
      offer(ACT_START, '0, '0, '0);
      offer(ACT_END, '0, 64'd999, '0);
      // The end time wraps past 2^64 on the last slot of the table.
      offer(ACT_START, '1, '1, '0);
      offer(ACT_END, '1, 64'd1999, '0);
      // A second start overwrites the first; the bucket is capped at the top one.
      offer(ACT_START, SLOT_W'(7), '0, '0);
      offer(ACT_START, SLOT_W'(7), 64'd5000, '0);
      offer(ACT_END, SLOT_W'(7), 64'd5000 + 64'd1000 * (64'd1 << 27), '0);
      // The largest latency possible, then a repeated end on the now closed slot.
      offer(ACT_START, SLOT_W'(8), '0, '0);
      offer(ACT_END, SLOT_W'(8), '1, '0);
      offer(ACT_END, SLOT_W'(8), '1, '0);
      // One microsecond gives bucket zero.
      offer(ACT_START, SLOT_W'(9), 64'd123, '0);
      offer(ACT_END, SLOT_W'(9), 64'd2122, '0);
      // Either side of the cap: 2^26 - 1 microseconds and exactly 2^26.
      offer(ACT_START, SLOT_W'(10), 64'h8000_0000_0000_0000, '0);
      offer(ACT_END, SLOT_W'(10),
            64'h8000_0000_0000_0000 + 64'd1000 * ((64'd1 << 26) - 64'd1), '0);
      offer(ACT_START, SLOT_W'(11), '0, '0);
      offer(ACT_END, SLOT_W'(11), 64'd1000 * (64'd1 << 26), '0);
      // Read back what the directed ends have gathered.
      offer(ACT_READ, '0, '0, '0);
      offer(ACT_READ, '0, '0, RIDX_W'(1));
      offer(ACT_READ, '0, '0, RIDX_W'(TOP_BUCKET));
      offer(ACT_READ, '0, '0, RIDX_W'(SUM_INDEX));

      // Random part, with a receiver hold-off part way through, a pause until every reply
      // has come back, and a stretch in which neither side idles.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 250) begin
            hold_off_request = 1'b1;
         end
         if (n == 450) begin
            drain();
         end
         steady = (n >= 520 && n < 640);
         random_item();
      end

      drain();
      if (board.fault_count == 0) begin
         $display("event_latency_log2_histogram_core_test: clean");
      end else begin
         $display("event_latency_log2_histogram_core_test: errors");
      end
      $finish;
   end

endmodule
